>>> hw/rtl/dfd_pkg.sv
// shared types, link symbols and crc-16 nibble table for the dle frame decoder
// no dependencies
package dfd_pkg;

  localparam int DFD_MAX_FRAME_BYTES = 256;
  localparam int DFD_LEN_OUT_W       = 9;

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_DLE = 8'h10;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // decoder state apart from the length counter, whose width follows the parameter
  typedef struct packed {
    logic        escape_pending;
    logic [15:0] crc_running;
    logic [7:0]  held_older;
    logic [7:0]  held_newer;
    logic [1:0]  held_count;
    logic        length_overflow;
  } dfd_state_t;

  typedef struct packed {
    logic                     valid;
    logic                     kind;
    logic [7:0]               data;
    logic                     frame_ok;
    logic [DFD_LEN_OUT_W-1:0] frame_length;
  } dfd_result_t;

  // poly 0x1021 times one nibble
  function automatic logic [15:0] crc_nib(input logic [3:0] k);
    logic [15:0] v;
    unique case (k)
      4'h0: v = 16'h0000;
      4'h1: v = 16'h1021;
      4'h2: v = 16'h2042;
      4'h3: v = 16'h3063;
      4'h4: v = 16'h4084;
      4'h5: v = 16'h50a5;
      4'h6: v = 16'h60c6;
      4'h7: v = 16'h70e7;
      4'h8: v = 16'h8108;
      4'h9: v = 16'h9129;
      4'ha: v = 16'ha14a;
      4'hb: v = 16'hb16b;
      4'hc: v = 16'hc18c;
      4'hd: v = 16'hd1ad;
      4'he: v = 16'he1ce;
      default: v = 16'hf1ef;
    endcase
    return v;
  endfunction

  // one byte, high nibble first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] c1;
    c1 = crc_nib(c[15:12] ^ b[7:4]) ^ {c[11:0], 4'h0};
    return crc_nib(c1[15:12] ^ b[3:0]) ^ {c1[11:0], 4'h0};
  endfunction

endpackage

>>> hw/rtl/dfd_decoder.sv
// next-state and result logic for one raw link byte
// depends on dfd_pkg
module dfd_decoder #(
  parameter int MAX_FRAME_BYTES = dfd_pkg::DFD_MAX_FRAME_BYTES,
  parameter int LEN_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic [7:0]         rx_byte,
  input  dfd_pkg::dfd_state_t st,
  input  logic [LEN_W-1:0]   len,
  output dfd_pkg::dfd_state_t st_nxt,
  output logic [LEN_W-1:0]   len_nxt,
  output dfd_pkg::dfd_result_t res
);
  import dfd_pkg::*;

  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_FRAME_BYTES);
  localparam logic [LEN_W-1:0] LenMin = LEN_W'(3);

  logic        is_soh, is_dle, is_eot;
  logic [15:0] tail;

  assign is_soh = (rx_byte == SYM_SOH);
  assign is_dle = (rx_byte == SYM_DLE);
  assign is_eot = (rx_byte == SYM_EOT);
  assign tail   = {st.held_newer, st.held_older};

  always_comb begin
    st_nxt = st;
    len_nxt = len;
    res = '0;
    priority if (!st.escape_pending && is_soh) begin
      st_nxt = '0;
      len_nxt = '0;
    end else if (!st.escape_pending && is_dle) begin
      st_nxt.escape_pending = 1'b1;
    end else if (!st.escape_pending && is_eot) begin
      res.valid        = 1'b1;
      res.kind         = KIND_REPORT;
      res.frame_ok     = (len >= LenMin) && !st.length_overflow && (st.crc_running == tail);
      res.frame_length = DFD_LEN_OUT_W'(len);
    end else begin
      // payload byte, escaped or plain
      st_nxt.escape_pending = 1'b0;
      if (len < LenMax) begin
        len_nxt = len + LEN_W'(1);
      end else begin
        st_nxt.length_overflow = 1'b1;
      end
      if (st.held_count >= 2'd2) begin
        res.valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = st.held_older;
        st_nxt.crc_running = crc_byte(st.crc_running, st.held_older);
      end else begin
        st_nxt.held_count = st.held_count + 2'd1;
      end
      st_nxt.held_older = st.held_newer;
      st_nxt.held_newer = rx_byte;
    end
  end

endmodule

>>> hw/rtl/dle_frame_decoder_crc16.sv
// top level of the soh/eot/dle frame decoder with crc-16 (poly 0x1021, init 0)
// depends on dfd_pkg and dfd_decoder
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | in_rx_byte
//   out_    | output    | out_valid / out_stall| out_kind, out_byte, out_frame_ok,
//           |           |                     | out_frame_length
//
// one byte per cycle sustained unless out_stall holds the pipe: each beat lands
// in an input register, and combinational decode and crc logic (two nibble
// lookups) feeds the result register
// rst_n is synchronous, active low; it clears the frame state and both valids
// out_stall only holds the pipe when a byte that makes a result meets a full
// result register; bytes that make no result pass through regardless
module dle_frame_decoder_crc16 #(
  parameter int MAX_FRAME_BYTES = dfd_pkg::DFD_MAX_FRAME_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [7:0]                        out_byte,
  output logic                              out_frame_ok,
  output logic [dfd_pkg::DFD_LEN_OUT_W-1:0] out_frame_length
);
  import dfd_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // frame state
  dfd_state_t       st_r, st_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // result register
  dfd_result_t res;
  logic        out_vld_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_ok_r;
  logic [DFD_LEN_OUT_W-1:0] out_len_r;

  logic out_free;
  logic advance;

  dfd_decoder #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .LEN_W           (LEN_W)
  ) u_dec (
    .rx_byte (in_byte_r),
    .st      (st_r),
    .len     (len_r),
    .st_nxt  (st_nxt),
    .len_nxt (len_nxt),
    .res     (res)
  );

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || !out_stall;
  // the held beat commits when it makes no result or the result slot is free
  assign advance  = in_vld_r && (!res.valid || out_free);
  // the input register takes a new beat whenever its current one moves on
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      len_r <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.data;
      out_ok_r   <= res.frame_ok;
      out_len_r  <= res.frame_length;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_kind_r;
  assign out_byte         = out_byte_r;
  assign out_frame_ok     = out_ok_r;
  assign out_frame_length = out_len_r;

endmodule
